### rtl/mfs_pkg.sv
// Shared constants, types and a helper function of the multilevel feedback scheduler.
`default_nettype none

package mfs_pkg;

    // Defaults of the top-level parameters.
    localparam int MFS_MAX_PROCS  = 16;
    localparam int MFS_NUM_LEVELS = 6;

    // Fixed field widths.
    localparam int PID_W       = 4;
    localparam int PRIO_W      = 3;
    localparam int QUANT_W     = 10;
    localparam int BURST_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int LVL_FIELD_W = 3;

    // Number of levels that have a programmable quantum register.
    localparam int NUM_QREGS = 6;

    // Operation codes of a request.
    typedef enum logic {
        OP_INSERT   = 1'b0,
        OP_DISPATCH = 1'b1
    } op_t;

    // Enqueue request from the scheduling logic to the level queues.
    typedef struct packed {
        logic                   valid;
        logic [PID_W-1:0]       pid;
        logic [LVL_FIELD_W-1:0] lvl;
    } ins_req_t;

    // Dequeue result of the level queues.
    typedef struct packed {
        logic                   valid;
        logic [PID_W-1:0]       pid;
        logic [LVL_FIELD_W-1:0] lvl;
    } pop_rsp_t;

    // Write into the per-process priority table.
    typedef struct packed {
        logic              valid;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } prio_wr_t;

    // Quantum of a level after reset, and the fixed quantum of levels without a register.
    function automatic logic [QUANT_W-1:0] default_quantum(input int lvl);
        return QUANT_W'(5 * (lvl + 1));
    endfunction

endpackage

`default_nettype wire

### rtl/mfs_proc_table.sv
// Per-process state: queued flags and the stored priority table.
`default_nettype none

module mfs_proc_table
    import mfs_pkg::*;
#(
    parameter int MaxProcs = MFS_MAX_PROCS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [PID_W-1:0]  rd_pid,
    input  wire logic [PID_W-1:0]  look_pid,
    input  wire prio_wr_t          prio_wr,
    input  wire logic              set_en,
    input  wire logic [PID_W-1:0]  set_pid,
    input  wire logic              clr_en,
    input  wire logic [PID_W-1:0]  clr_pid,
    output logic                   enq_allowed,
    output logic [PRIO_W-1:0]      prio_rd
);

    localparam int PIDX_W = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;

    logic [MaxProcs-1:0] queued_reg;
    logic [PRIO_W-1:0]   prio_mem [MaxProcs];
    logic [PRIO_W-1:0]   prio_q_reg;
    logic                byp_reg;
    logic [PRIO_W-1:0]   byp_prio_reg;
    logic                look_in_range;

    assign look_in_range = (32'(look_pid) < 32'(MaxProcs));

    // Out-of-range processes are never queued and are rejected here.
    always_comb begin
        enq_allowed = 1'b0;
        if (look_in_range) begin
            enq_allowed = !queued_reg[PIDX_W'(look_pid)];
        end
    end

    // Set before clear: a re-queued process that is popped in the same request ends unqueued.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg <= '0;
        end else begin
            if (set_en) begin
                queued_reg[PIDX_W'(set_pid)] <= 1'b1;
            end
            if (clr_en) begin
                queued_reg[PIDX_W'(clr_pid)] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prio_wr.valid) begin
            prio_mem[PIDX_W'(prio_wr.pid)] <= prio_wr.prio;
        end
        if (rd_en) begin
            prio_q_reg <= prio_mem[PIDX_W'(rd_pid)];
        end
    end

    // A read that collides with a write at the same edge takes the new value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= prio_wr.valid && (prio_wr.pid == rd_pid);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_prio_reg <= prio_wr.prio;
        end
    end

    assign prio_rd = byp_reg ? byp_prio_reg : prio_q_reg;

endmodule

`default_nettype wire

### rtl/mfs_level_queues.sv
// Ring-buffer FIFO levels with head registers and a prefetched front entry per level.
`default_nettype none

module mfs_level_queues
    import mfs_pkg::*;
#(
    parameter int MaxProcs  = MFS_MAX_PROCS,
    parameter int NumLevels = MFS_NUM_LEVELS
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      commit,
    input  wire ins_req_t  ins,
    input  wire logic      pop_req,
    output logic           all_empty,
    output logic           ins_ok,
    output pop_rsp_t       pop
);

    localparam int IDX_W = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
    localparam int CNT_W = $clog2(MaxProcs + 1);
    localparam int LVL_W = $clog2(NumLevels);

    logic [IDX_W-1:0] head_reg  [NumLevels];
    logic [CNT_W-1:0] count_reg [NumLevels];
    logic [PID_W-1:0] front_reg [NumLevels];
    logic [PID_W-1:0] ring_mem  [NumLevels][MaxProcs];
    logic [PID_W-1:0] ring_q_reg;

    logic             rf_valid_reg;
    logic [LVL_W-1:0] rf_lvl_reg;
    logic             rf_byp_reg;
    logic [PID_W-1:0] rf_byp_pid_reg;
    logic [PID_W-1:0] rf_data;

    logic [NumLevels-1:0] nonempty_pre;
    logic [NumLevels-1:0] nonempty_post;
    logic [LVL_W-1:0]     ins_lvl;
    logic [LVL_W-1:0]     pop_lvl;
    logic                 pop_valid;
    logic                 pop_fire;
    logic                 ins_fire;
    logic                 ins_here;
    logic [CNT_W-1:0]     pop_cnt;
    logic [IDX_W-1:0]     head_inc;
    logic [PID_W-1:0]     front_eff;
    logic                 refill;
    logic                 refill_byp;
    logic [CNT_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail_idx;
    logic [CNT_W-1:0]     count_next [NumLevels];

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] h);
        logic [IDX_W:0] s;
        s = {1'b0, h} + (IDX_W+1)'(1);
        return (s >= (IDX_W+1)'(MaxProcs)) ? '0 : s[IDX_W-1:0];
    endfunction

    assign rf_data = rf_byp_reg ? rf_byp_pid_reg : ring_q_reg;
    assign ins_lvl = LVL_W'(ins.lvl);
    assign ins_ok  = ins.valid && (count_reg[ins_lvl] < CNT_W'(MaxProcs));

    always_comb begin
        for (int l = 0; l < NumLevels; l++) begin
            nonempty_pre[l]  = (count_reg[l] != '0);
            nonempty_post[l] = nonempty_pre[l] || (ins_ok && (ins_lvl == LVL_W'(l)));
        end
    end

    assign all_empty = ~|nonempty_pre;

    // Lowest-numbered non-empty level wins.
    always_comb begin
        pop_lvl = '0;
        for (int l = NumLevels - 1; l >= 0; l--) begin
            if (nonempty_post[l]) begin
                pop_lvl = LVL_W'(l);
            end
        end
    end

    assign pop_valid = pop_req && (|nonempty_post);
    assign pop_fire  = commit && pop_valid;
    assign ins_fire  = commit && ins_ok;
    assign ins_here  = ins_ok && (ins_lvl == pop_lvl);
    assign pop_cnt   = count_reg[pop_lvl];
    assign head_inc  = ring_inc(head_reg[pop_lvl]);

    // The front of a level may still be arriving from the ring read of the previous pop.
    assign front_eff = (rf_valid_reg && (rf_lvl_reg == pop_lvl)) ? rf_data : front_reg[pop_lvl];

    always_comb begin
        pop.valid = pop_valid;
        pop.lvl   = LVL_FIELD_W'(pop_lvl);
        pop.pid   = (ins_here && (pop_cnt == '0)) ? ins.pid : front_eff;
    end

    // A refill is needed when the popped level keeps at least one entry.
    assign refill     = (pop_cnt >= CNT_W'(2)) || ((pop_cnt == CNT_W'(1)) && ins_here);
    assign refill_byp = ins_here && (pop_cnt == CNT_W'(1));

    assign tail_sum = (CNT_W+1)'(head_reg[ins_lvl]) + (CNT_W+1)'(count_reg[ins_lvl]);
    assign tail_idx = (tail_sum >= (CNT_W+1)'(MaxProcs)) ?
                      IDX_W'(tail_sum - (CNT_W+1)'(MaxProcs)) : IDX_W'(tail_sum);

    always_comb begin
        for (int l = 0; l < NumLevels; l++) begin
            count_next[l] = count_reg[l]
                          + CNT_W'(ins_fire && (ins_lvl == LVL_W'(l)))
                          - CNT_W'(pop_fire && (pop_lvl == LVL_W'(l)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NumLevels; l++) begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            rf_valid_reg <= 1'b0;
            rf_lvl_reg   <= '0;
            rf_byp_reg   <= 1'b0;
        end else begin
            for (int l = 0; l < NumLevels; l++) begin
                count_reg[l] <= count_next[l];
            end
            if (pop_fire) begin
                head_reg[pop_lvl] <= head_inc;
            end
            rf_valid_reg <= pop_fire && refill;
            if (pop_fire) begin
                rf_lvl_reg <= pop_lvl;
                rf_byp_reg <= refill_byp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_valid_reg) begin
            front_reg[rf_lvl_reg] <= rf_data;
        end
        if (ins_fire && (count_reg[ins_lvl] == '0)) begin
            front_reg[ins_lvl] <= ins.pid;
        end
        if (pop_fire) begin
            rf_byp_pid_reg <= ins.pid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_fire) begin
            ring_mem[ins_lvl][tail_idx] <= ins.pid;
        end
        if (pop_fire) begin
            ring_q_reg <= ring_mem[pop_lvl][head_inc];
        end
    end

endmodule

`default_nettype wire

### rtl/multilevel_feedback_scheduler.sv
// Top level of the multilevel feedback scheduler: request stage, priority logic, result register.
//
//   Channel   Direction  Handshake              Carries
//   s_*       in         s_valid / s_ready      one insert or dispatch request
//   m_*       out        m_valid / m_ready      one result per request
//   cfg_*     in         cfg_valid / cfg_ready  quantum register writes
//
// A request is accepted into a stage register and its result is loaded into the output
// register when the stage commits, so a new request can be accepted every cycle while the
// output is not stalled. The priority table is read at the acceptance edge.
// Reset clears the queues, the queued flags and the running process at once; no sweep runs.
// A stalled output holds the stage, and s_ready drops only while the stage and the output
// are both full and m_ready is low.
`default_nettype none

module multilevel_feedback_scheduler
    import mfs_pkg::*;
#(
    parameter int MaxProcs  = MFS_MAX_PROCS,
    parameter int NumLevels = MFS_NUM_LEVELS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [PID_W-1:0]     s_process_id,
    input  wire logic                 s_is_new,
    input  wire logic [BURST_W-1:0]   s_last_burst,
    input  wire logic                 s_still_running,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_accepted,
    output logic [PRIO_W-1:0]         m_assigned_priority,
    output logic                      m_dispatched_valid,
    output logic [PID_W-1:0]          m_dispatched_pid,
    output logic [QUANT_W-1:0]        m_timer_quantum,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [QUANT_W-1:0]   cfg_data
);

    localparam int LVL_W = $clog2(NumLevels);
    localparam logic [PRIO_W-1:0] TopPrio = PRIO_W'(NumLevels - 1);

    // Request stage.
    logic               stage_valid_reg;
    op_t                op_reg;
    logic [PID_W-1:0]   pid_reg;
    logic               is_new_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               still_reg;

    // Scheduler state outside the queues.
    logic               running_valid_reg;
    logic [PID_W-1:0]   running_pid_reg;
    logic [QUANT_W-1:0] cq_reg;
    logic [QUANT_W-1:0] quant_reg [NUM_QREGS];
    logic [QUANT_W-1:0] level_quantum [NumLevels];

    // Result register.
    logic               m_valid_reg;
    logic               m_accepted_reg;
    logic [PRIO_W-1:0]  m_prio_reg;
    logic               m_dv_reg;
    logic [PID_W-1:0]   m_dpid_reg;
    logic [QUANT_W-1:0] m_quant_reg;

    logic               accept;
    logic               commit;
    logic               is_dispatch;
    logic               ins_try;
    logic [PID_W-1:0]   ins_pid;
    logic               enq_allowed;
    logic               enq_go;
    logic [PRIO_W-1:0]  stored_prio;
    logic [PRIO_W-1:0]  base_prio;
    logic [PRIO_W-1:0]  new_prio;
    logic [19:0]        burst_x10;
    logic [13:0]        cq_x9;
    logic               long_burst;
    logic               short_burst;
    logic               all_empty;
    logic               ins_ok;
    ins_req_t           ins;
    pop_rsp_t           pop;
    prio_wr_t           prio_wr;
    logic [PID_W-1:0]   run_pid_next;
    logic [PID_W-1:0]   rd_pid;
    logic [QUANT_W-1:0] cq_next;

    assign commit  = stage_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (accept) begin
            stage_valid_reg <= 1'b1;
        end else if (commit) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= op_t'(s_op);
            pid_reg    <= s_process_id;
            is_new_reg <= s_is_new;
            burst_reg  <= s_last_burst;
            still_reg  <= s_still_running;
        end
    end

    // A dispatch first re-queues the running process when it is still runnable,
    // using the burst and the new flag that came with the dispatch request.
    assign is_dispatch = (op_reg == OP_DISPATCH);
    assign ins_pid     = is_dispatch ? running_pid_reg : pid_reg;
    assign ins_try     = is_dispatch ? (running_valid_reg && still_reg) : 1'b1;
    assign enq_go      = ins_try && enq_allowed;

    // Burst against 0.9 and 0.5 of the current quantum, scaled to integers.
    assign burst_x10   = 20'({burst_reg, 3'b000}) + 20'({burst_reg, 1'b0});
    assign cq_x9       = 14'({cq_reg, 3'b000}) + 14'(cq_reg);
    assign long_burst  = burst_x10 > 20'(cq_x9);
    assign short_burst = {burst_reg, 1'b0} < 17'(cq_reg);

    assign base_prio = (stored_prio > TopPrio) ? TopPrio : stored_prio;

    always_comb begin
        if (all_empty || is_new_reg) begin
            new_prio = TopPrio;
        end else if (long_burst) begin
            new_prio = (base_prio != '0) ? base_prio - PRIO_W'(1) : base_prio;
        end else if (short_burst) begin
            new_prio = (base_prio != TopPrio) ? base_prio + PRIO_W'(1) : base_prio;
        end else begin
            new_prio = base_prio;
        end
    end

    always_comb begin
        ins.valid = enq_go;
        ins.pid   = ins_pid;
        ins.lvl   = LVL_FIELD_W'(TopPrio - new_prio);
    end

    // The priority is stored even when the target level turns out to be full.
    always_comb begin
        prio_wr.valid = commit && enq_go;
        prio_wr.pid   = ins_pid;
        prio_wr.prio  = new_prio;
    end

    mfs_level_queues #(
        .MaxProcs  (MaxProcs),
        .NumLevels (NumLevels)
    ) u_queues (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .commit    (commit),
        .ins       (ins),
        .pop_req   (is_dispatch),
        .all_empty (all_empty),
        .ins_ok    (ins_ok),
        .pop       (pop)
    );

    // The next request reads the table for the process it will insert. For a dispatch
    // that is the running process as it stands after the request now leaving the stage.
    assign run_pid_next = (commit && pop.valid) ? pop.pid : running_pid_reg;
    assign rd_pid       = (op_t'(s_op) == OP_DISPATCH) ? run_pid_next : s_process_id;

    mfs_proc_table #(
        .MaxProcs (MaxProcs)
    ) u_proc_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_en       (accept),
        .rd_pid      (rd_pid),
        .look_pid    (ins_pid),
        .prio_wr     (prio_wr),
        .set_en      (commit && ins_ok),
        .set_pid     (ins_pid),
        .clr_en      (commit && pop.valid),
        .clr_pid     (pop.pid),
        .enq_allowed (enq_allowed),
        .prio_rd     (stored_prio)
    );

    // Levels past the register file have a fixed quantum.
    for (genvar l = 0; l < NumLevels; l++) begin : g_level_quantum
        if (l < NUM_QREGS) begin : g_reg
            assign level_quantum[l] = quant_reg[l];
        end else begin : g_fixed
            assign level_quantum[l] = default_quantum(l);
        end
    end

    assign cq_next = pop.valid ? level_quantum[LVL_W'(pop.lvl)] : cq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_valid_reg <= 1'b0;
            running_pid_reg   <= '0;
            cq_reg            <= QUANT_W'(5);
        end else if (commit && is_dispatch) begin
            running_valid_reg <= pop.valid;
            running_pid_reg   <= run_pid_next;
            cq_reg            <= cq_next;
        end
    end

    // Quantum registers; a write to a level that does not exist is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QREGS; i++) begin
                quant_reg[i] <= default_quantum(i);
            end
        end else if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_QREGS)
                     && (32'(cfg_index) < NumLevels)) begin
            quant_reg[cfg_index] <= cfg_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_accepted_reg <= !is_dispatch && ins_ok;
            m_prio_reg     <= (!is_dispatch && ins_ok) ? new_prio : '0;
            m_dv_reg       <= pop.valid;
            m_dpid_reg     <= pop.valid ? pop.pid : '0;
            m_quant_reg    <= is_dispatch ? cq_next : cq_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_accepted          = m_accepted_reg;
    assign m_assigned_priority = m_prio_reg;
    assign m_dispatched_valid  = m_dv_reg;
    assign m_dispatched_pid    = m_dpid_reg;
    assign m_timer_quantum     = m_quant_reg;

`ifndef SYNTHESIS
    // A dispatch that selects a process leaves that process running.
    a_dispatch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && is_dispatch && pop.valid) |=>
            (running_valid_reg && (running_pid_reg == $past(pop.pid))))
        else $error("dispatched process is not the running one");

    // With every level empty and nothing re-queued, a dispatch finds nothing.
    a_idle_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && is_dispatch && all_empty && !ins_ok) |-> !pop.valid)
        else $error("dispatch popped from empty levels");

    // An insert result never reports a dispatch.
    a_insert_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !is_dispatch) |=> (m_valid && !m_dispatched_valid))
        else $error("insert result carries a dispatch");

    // An accepted insert never gets a priority above the top level.
    a_prio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_assigned_priority <= TopPrio))
        else $error("assigned priority out of range");
`endif

endmodule

`default_nettype wire

### tb/sv/mfs_dispatch_checker.sv
// Checker that mirrors the scheduler state, predicts every result and compares it.
`timescale 1ns / 100ps

module mfs_dispatch_checker
    import mfs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic                 s_op,
    input  wire logic [PID_W-1:0]     s_process_id,
    input  wire logic                 s_is_new,
    input  wire logic [BURST_W-1:0]   s_last_burst,
    input  wire logic                 s_still_running,

    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic                 m_accepted,
    input  wire logic [PRIO_W-1:0]    m_assigned_priority,
    input  wire logic                 m_dispatched_valid,
    input  wire logic [PID_W-1:0]     m_dispatched_pid,
    input  wire logic [QUANT_W-1:0]   m_timer_quantum,

    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [QUANT_W-1:0]   cfg_data,

    output int                        mismatch_count,
    output int                        pending_count,
    output int                        results_checked,
    output int                        dispatches_seen
);

    localparam int LEVELS       = MFS_NUM_LEVELS;
    localparam int PROCS        = MFS_MAX_PROCS;
    localparam int TOP_PRIO     = LEVELS - 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                accepted;
        logic [PRIO_W-1:0]   prio;
        logic                dvalid;
        logic [PID_W-1:0]    dpid;
        logic [QUANT_W-1:0]  quantum;
    } sched_result_t;

    // Mirror of the scheduler state.
    logic [QUANT_W-1:0] level_quantum [LEVELS];
    logic [PID_W-1:0]   level_ring    [LEVELS][PROCS];
    logic [PID_W-1:0]   level_head    [LEVELS];
    logic [4:0]         level_depth   [LEVELS];
    logic               queued        [PROCS];
    logic [PRIO_W-1:0]  prio_table    [PROCS];
    logic               run_valid;
    logic [PID_W-1:0]   run_pid;
    logic [QUANT_W-1:0] cur_quantum;

    sched_result_t expected_outcomes [$];
    sched_result_t observed;
    sched_result_t predicted;
    int mismatches;
    int checked;
    int dispatched;
    int idx;

    function automatic bit levels_empty();
        int l;
        for (l = 0; l < LEVELS; l++)
            if (level_depth[l] != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Queues a process unless it is already waiting or its level is full; returns 1 when it was queued.
    function automatic bit enqueue_process(input logic [PID_W-1:0] pid, input logic is_new,
            input logic [BURST_W-1:0] burst, output logic [PRIO_W-1:0] prio);
        int p;
        int lvl;
        prio = '0;
        if (queued[pid])
            return 1'b0;
        if (levels_empty() || is_new) begin
            p = TOP_PRIO;
        end else begin
            p = prio_table[pid];
            if (p > TOP_PRIO)
                p = TOP_PRIO;
            // Long bursts sink a process, short ones lift it.
            if (10 * int'(burst) > 9 * int'(cur_quantum)) begin
                if (p != 0)
                    p--;
            end else if (2 * int'(burst) < int'(cur_quantum)) begin
                if (p != TOP_PRIO)
                    p++;
            end
        end
        prio_table[pid] = PRIO_W'(p);
        lvl = TOP_PRIO - p;
        if (level_depth[lvl] >= PROCS)
            return 1'b0;
        level_ring[lvl][PID_W'(level_head[lvl] + level_depth[lvl])] = pid;
        level_depth[lvl] = level_depth[lvl] + 1'b1;
        queued[pid] = 1'b1;
        prio = PRIO_W'(p);
        return 1'b1;
    endfunction

    function automatic sched_result_t predict_schedule(input op_t op,
            input logic [PID_W-1:0] pid, input logic is_new,
            input logic [BURST_W-1:0] burst, input logic still);
        sched_result_t outcome;
        logic [PRIO_W-1:0] prio;
        bit found;
        int l;
        outcome = '0;
        prio = '0;
        found = 1'b0;
        if (op == OP_INSERT) begin
            if (enqueue_process(pid, is_new, burst, prio)) begin
                outcome.accepted = 1'b1;
                outcome.prio = prio;
            end
        end else begin
            if (run_valid && still)
                void'(enqueue_process(run_pid, is_new, burst, prio));
            run_valid = 1'b0;
            for (l = 0; l < LEVELS; l++) begin
                if (!found && level_depth[l] != 0) begin
                    run_pid = level_ring[l][level_head[l]];
                    level_head[l] = level_head[l] + 1'b1;
                    level_depth[l] = level_depth[l] - 1'b1;
                    queued[run_pid] = 1'b0;
                    run_valid = 1'b1;
                    cur_quantum = level_quantum[l];
                    outcome.dvalid = 1'b1;
                    outcome.dpid = run_pid;
                    found = 1'b1;
                end
            end
        end
        outcome.quantum = cur_quantum;
        return outcome;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (idx = 0; idx < LEVELS; idx++) begin
                level_quantum[idx] = QUANT_W'(5 * (idx + 1));
                level_head[idx] = '0;
                level_depth[idx] = '0;
            end
            for (idx = 0; idx < PROCS; idx++)
                queued[idx] = 1'b0;
            run_valid = 1'b0;
            run_pid = '0;
            cur_quantum = QUANT_W'(5);
            expected_outcomes.delete();
            mismatches = 0;
            checked = 0;
            dispatched = 0;
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_QREGS)
                level_quantum[cfg_index] = cfg_data;
            if (s_valid && s_ready)
                expected_outcomes.push_back(predict_schedule(op_t'(s_op), s_process_id,
                    s_is_new, s_last_burst, s_still_running));
            if (m_valid && m_ready) begin
                observed = {m_accepted, m_assigned_priority, m_dispatched_valid,
                            m_dispatched_pid, m_timer_quantum};
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $write("%0t: result with no request pending: ", $time);
                        $display("acc=%0d prio=%0d dv=%0d pid=%0d q=%0d",
                            observed.accepted, observed.prio, observed.dvalid,
                            observed.dpid, observed.quantum);
                    end
                end else begin
                    predicted = expected_outcomes.pop_front();
                    checked++;
                    if (predicted.dvalid)
                        dispatched++;
                    if (observed.accepted !== predicted.accepted ||
                            observed.prio !== predicted.prio ||
                            observed.dvalid !== predicted.dvalid ||
                            observed.dpid !== predicted.dpid ||
                            observed.quantum !== predicted.quantum) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $write("%0t: result mismatch: expected acc=%0d prio=%0d ",
                                $time, predicted.accepted, predicted.prio);
                            $write("dv=%0d pid=%0d q=%0d, ",
                                predicted.dvalid, predicted.dpid, predicted.quantum);
                            $display("got acc=%0d prio=%0d dv=%0d pid=%0d q=%0d",
                                observed.accepted, observed.prio, observed.dvalid,
                                observed.dpid, observed.quantum);
                        end
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        pending_count <= expected_outcomes.size();
        results_checked <= checked;
        dispatches_seen <= dispatched;
    end

endmodule

### tb/sv/tb_multilevel_feedback_scheduler.sv
// Testbench top of the multilevel feedback scheduler: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_multilevel_feedback_scheduler;
    import mfs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 120;
    localparam logic [QUANT_W-1:0] QUANT_MIN = QUANT_W'(1);
    localparam logic [QUANT_W-1:0] QUANT_MAX = {QUANT_W{1'b1}};

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [QUANT_W-1:0]   data;
    } quantum_write_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Every input of the block starts at a known value.
    logic                 s_valid         = 1'b0;
    logic                 s_op            = OP_INSERT;
    logic [PID_W-1:0]     s_process_id    = '0;
    logic                 s_is_new        = 1'b0;
    logic [BURST_W-1:0]   s_last_burst    = '0;
    logic                 s_still_running = 1'b0;
    logic                 m_ready         = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [QUANT_W-1:0]   cfg_data        = '0;

    logic                 s_ready;
    logic                 m_valid;
    logic                 m_accepted;
    logic [PRIO_W-1:0]    m_assigned_priority;
    logic                 m_dispatched_valid;
    logic [PID_W-1:0]     m_dispatched_pid;
    logic [QUANT_W-1:0]   m_timer_quantum;
    logic                 cfg_ready;

    int mismatch_count;
    int pending_count;
    int results_checked;
    int dispatches_seen;

    // Pacing knobs: the sender's idle chance is only read by the stimulus process, the
    // receiver's stall chance and the hold-off trigger are handed over with NBAs.
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    logic hold_trigger    = 1'b0;
    int   hold_left       = 0;
    int   cycle_count     = 0;
    int   requests_sent   = 0;

    // A process whose priority was never stored must not be inserted as an old process
    // while other processes wait, so its first insert is always marked as new.
    bit prio_written [MFS_MAX_PROCS];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    multilevel_feedback_scheduler dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_process_id        (s_process_id),
        .s_is_new            (s_is_new),
        .s_last_burst        (s_last_burst),
        .s_still_running     (s_still_running),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_assigned_priority (m_assigned_priority),
        .m_dispatched_valid  (m_dispatched_valid),
        .m_dispatched_pid    (m_dispatched_pid),
        .m_timer_quantum     (m_timer_quantum),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    mfs_dispatch_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_process_id        (s_process_id),
        .s_is_new            (s_is_new),
        .s_last_burst        (s_last_burst),
        .s_still_running     (s_still_running),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_accepted          (m_accepted),
        .m_assigned_priority (m_assigned_priority),
        .m_dispatched_valid  (m_dispatched_valid),
        .m_dispatched_pid    (m_dispatched_pid),
        .m_timer_quantum     (m_timer_quantum),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .pending_count       (pending_count),
        .results_checked     (results_checked),
        .dispatches_seen     (dispatches_seen)
    );

    // The run is cut off if it ever exceeds the cycle budget.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multilevel_feedback_scheduler regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls at the current rate, or a solid hold-off once triggered.
    // During the hold-off the block's stage and output register fill and s_ready drops.
    always @(posedge aclk) begin
        if (hold_trigger) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        if (hold_trigger || hold_left != 0) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one request and returns at the edge where it is accepted. Valid is only
    // lowered when an idle gap is inserted, so back-to-back requests keep it high.
    task automatic send_request(input op_t op, input logic [PID_W-1:0] pid,
            input logic is_new, input logic [BURST_W-1:0] burst, input logic still);
        logic fresh;
        fresh = is_new;
        if (op == OP_INSERT) begin
            if (!prio_written[pid])
                fresh = 1'b1;
            prio_written[pid] = 1'b1;
        end
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_process_id    <= pid;
        s_is_new        <= fresh;
        s_last_burst    <= burst;
        s_still_running <= still;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // Stops offering and waits until every predicted result has been taken. The extra
    // edge first lets the checker count a request accepted at the last edge.
    task automatic drain_requests();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_registers(input quantum_write_t writes[$]);
        foreach (writes[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= writes[i].index;
            cfg_data  <= writes[i].data;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        quantum_write_t     writes [$];
        logic [QUANT_W-1:0] q;
        logic [BURST_W-1:0] burst;
        op_t                op;
        int                 phase;
        int                 n;
        int                 lvl;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the quantums left at their reset values.
        // Dispatching with every level empty leaves the running slot and quantum alone,
        // whether or not still_running is set.
        send_request(OP_DISPATCH, 4'd0, 1'b0, 16'd0, 1'b0);
        send_request(OP_DISPATCH, 4'd9, 1'b1, 16'hFFFF, 1'b1);
        // Inserts into empty levels get the top priority; a repeat insert is ignored.
        send_request(OP_INSERT, 4'd0, 1'b1, 16'd0, 1'b0);
        send_request(OP_INSERT, 4'd15, 1'b0, 16'hFFFF, 1'b1);
        send_request(OP_INSERT, 4'd0, 1'b0, 16'd0, 1'b0);
        send_request(OP_INSERT, 4'd7, 1'b1, 16'd1234, 1'b0);
        send_request(OP_DISPATCH, 4'd0, 1'b0, 16'd0, 1'b0);
        // A long burst sinks the running process, a zero burst tries to lift it past the
        // top, and a burst between half and nine tenths of the quantum keeps it in place.
        send_request(OP_DISPATCH, 4'd0, 1'b0, 16'hFFFF, 1'b1);
        send_request(OP_DISPATCH, 4'd0, 1'b0, 16'd0, 1'b1);
        send_request(OP_DISPATCH, 4'd0, 1'b0, 16'd3, 1'b1);
        send_request(OP_INSERT, 4'd0, 1'b0, 16'hFFFF, 1'b0);
        send_request(OP_INSERT, 4'd3, 1'b0, 16'd2, 1'b0);
        // A known process inserted as old while others wait, with a long burst.
        send_request(OP_INSERT, 4'd7, 1'b0, 16'hFFFF, 1'b0);
        send_request(OP_DISPATCH, 4'd0, 1'b1, 16'hFFFF, 1'b1);
        // Keep re-queuing the running process with long bursts so that it works its way
        // down through the lower levels and their quantums.
        repeat (7) send_request(OP_DISPATCH, 4'd0, 1'b0, 16'hFFFF, 1'b1);
        // Drain every level and dispatch once more on empty levels.
        repeat (5) send_request(OP_DISPATCH, 4'd0, 1'b0, 16'd0, 1'b0);
        drain_requests();

        // Random phases, each with its own pacing and quantum setting.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct = 50;
                    recv_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct <= 50;
                end
                default: begin
                    sender_idle_pct = 21;
                    recv_stall_pct <= 21;
                end
            endcase

            // Largest quantums, then smallest, then random ones. The third setting also
            // gives one level a zero quantum and writes the two indexes with no register.
            writes.delete();
            for (lvl = 0; lvl < NUM_QREGS; lvl++) begin
                case (phase)
                    0: q = QUANT_MAX;
                    1: q = QUANT_MIN;
                    default: q = QUANT_W'($urandom_range(QUANT_MAX, QUANT_MIN));
                endcase
                writes.push_back('{index: CFG_IDX_W'(lvl), data: q});
            end
            if (phase == 2) begin
                writes[$urandom_range(NUM_QREGS - 1)].data = '0;
                writes.push_back('{index: CFG_IDX_W'(NUM_QREGS), data: QUANT_W'($urandom)});
                writes.push_back('{index: CFG_IDX_W'(NUM_QREGS + 1),
                                   data: QUANT_W'($urandom)});
            end
            program_registers(writes);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Once the receiver holds off for a long stretch while the sender keeps
                // offering, and once the sender waits until every result is back.
                if (phase == 0 && n == 40) begin
                    s_valid <= 1'b0;
                    hold_trigger <= 1'b1;
                    @(posedge aclk);
                    hold_trigger <= 1'b0;
                end
                if (phase == 1 && n == 75)
                    drain_requests();

                op = ($urandom_range(99) < 50) ? OP_INSERT : OP_DISPATCH;
                // Bursts are spread over short, medium and long relative to the quantum,
                // with some drawn from the full field.
                case ($urandom_range(3))
                    0: burst = BURST_W'($urandom_range(2));
                    1: burst = BURST_W'($urandom_range(1100));
                    2: burst = BURST_W'($urandom);
                    default: burst = BURST_W'($urandom_range(65535, 60000));
                endcase
                send_request(op, PID_W'($urandom_range(MFS_MAX_PROCS - 1)),
                             ($urandom_range(99) < 15), burst, ($urandom_range(99) < 65));
            end
            drain_requests();
        end

        $display("Checked %0d results from %0d requests under four pacing patterns.",
                 results_checked, requests_sent);
        $display("%0d dispatches selected a process %s", dispatches_seen,
                 "across reset, minimum, maximum and random quantums.");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("multilevel_feedback_scheduler regression: pass");
        end else begin
            $display("multilevel_feedback_scheduler regression: fail");
        end
        $finish;
    end

endmodule
